// ----- rtl/core/rabin_pkg.sv -----
// ----------------------------------------------------------------------------
// rabin_pkg
// shared types and codes of the rabin encrypt/decrypt block
// ----------------------------------------------------------------------------
package rabin_pkg;

    localparam logic [1:0] CFG_PRIME_P        = 2'd0;
    localparam logic [1:0] CFG_PRIME_Q        = 2'd1;
    localparam logic [1:0] CFG_PUBLIC_MODULUS = 2'd2;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ENC_DIV,
        S_ENC_MUL,
        S_INV_BEGIN,
        S_INV_INIT,
        S_INV_CHK,
        S_INV_DIV,
        S_INV_RED,
        S_INV_MUL,
        S_PROD,
        S_RES_P,
        S_RES_Q,
        S_POW_BEGIN,
        S_POW_CHK,
        S_POW_MUL1,
        S_POW_MUL2,
        S_NEG,
        S_CRT1,
        S_CRT2,
        S_CRT3,
        S_CRT4,
        S_EMIT,
        S_ERR_EMIT
    } seq_state_t;

endpackage

// ----- rtl/core/rabin_div.sv -----
// ----------------------------------------------------------------------------
// rabin_div
// restoring bit-serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rabin_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  dsr_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign shifted   = {rem_reg, quo_reg[W-1]};
    assign diff      = shifted - {1'b0, dsr_reg};
    assign done      = busy_reg && (cnt_reg == '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

endmodule

// ----- rtl/core/rabin_mulmod.sv -----
// ----------------------------------------------------------------------------
// rabin_mulmod
// shift-add modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module rabin_mulmod #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         plain,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] product
);

    logic         busy_reg;
    logic         plain_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] x_reg;
    logic [W-1:0] y_reg;
    logic [W-1:0] m_reg;
    logic [W:0]   sum_acc;
    logic [W:0]   sum_dbl;
    logic [W-1:0] acc_next;
    logic [W-1:0] x_next;

    assign sum_acc = {1'b0, acc_reg} + {1'b0, x_reg};
    assign sum_dbl = {1'b0, x_reg} + {1'b0, x_reg};
    assign done    = busy_reg && (y_reg == '0);
    assign product = acc_reg;

    always_comb
    begin
        if (plain_reg || (sum_acc < {1'b0, m_reg}))
        begin
            acc_next = sum_acc[W-1:0];
        end
        else
        begin
            acc_next = W'(sum_acc - {1'b0, m_reg});
        end
        if (plain_reg || (sum_dbl < {1'b0, m_reg}))
        begin
            x_next = sum_dbl[W-1:0];
        end
        else
        begin
            x_next = W'(sum_dbl - {1'b0, m_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            plain_reg <= plain;
            acc_reg   <= '0;
            x_reg     <= x;
            y_reg     <= y;
            m_reg     <= m;
        end
        else if (busy_reg && (y_reg != '0))
        begin
            if (y_reg[0])
            begin
                acc_reg <= acc_next;
            end
            x_reg <= x_next;
            y_reg <= y_reg >> 1;
        end
    end

endmodule

// ----- rtl/core/rabin_encrypt_decrypt.sv -----
// ----------------------------------------------------------------------------
// rabin_encrypt_decrypt
// rabin encryption and four-root decryption under a small sequencer
// ----------------------------------------------------------------------------
// One request at a time. All arithmetic runs on a bit-serial divider
// (width W = max(2*PRIME_BITS, 32)) and a shift-add modular multiplier that
// steps through the bits of the multiplier operand. Encrypt is one division
// and one multiply. Decrypt takes two extended-gcd inverses (a division, a
// reduction and a multiply per gcd step), two exponentiations (one or two
// multiplies per exponent bit), one plain multiply for the modulus and
// sixteen CRT multiplies; the four results then leave as each CRT pair
// finishes. A new request is taken once the last result of the previous
// one sits in the output register.
module rabin_encrypt_decrypt #(
    parameter int PRIME_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_value,
    output logic        last_result,
    output logic        error_flag
);

    import rabin_pkg::*;

    localparam int PB = PRIME_BITS;
    localparam int DW = (2 * PB > 32) ? 2 * PB : 32;

    seq_state_t state_reg, state_next;

    logic [PB-1:0] p_reg, q_reg;
    logic [31:0]   n_reg;
    logic          issued_reg, issued_next;
    logic [1:0]    k_reg, k_next;
    logic          which_reg, which_next;
    logic [31:0]   val_reg, val_next;
    logic [DW-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [DW-1:0] t0_reg, t0_next, t1_reg, t1_next;
    logic [DW-1:0] qt_reg, qt_next, rm_reg, rm_next;
    logic [DW-1:0] ip_reg, ip_next, iq_reg, iq_next;
    logic [DW-1:0] mm_reg, mm_next;
    logic [DW-1:0] cp_reg, cp_next, cq_reg, cq_next;
    logic [DW-1:0] acc_reg, acc_next, base_reg, base_next;
    logic [PB-1:0] e_reg, e_next;
    logic [DW-1:0] rp0_reg, rp0_next, rp1_reg, rp1_next;
    logic [DW-1:0] rq0_reg, rq0_next, rq1_reg, rq1_next;
    logic [DW-1:0] tc_reg, tc_next, t1c_reg, t1c_next;
    logic [31:0]   res_reg, res_next;
    logic          res_last_reg, res_last_next;

    logic          out_valid_reg, out_valid_next;
    logic [31:0]   out_value_reg, out_value_next;
    logic          out_last_reg, out_last_next;
    logic          out_err_reg, out_err_next;

    logic          in_acc, out_free;
    logic          uses_div, uses_mul, unit_done;
    logic          div_start, div_done;
    logic [DW-1:0] div_a, div_b, div_quo, div_rem;
    logic          mul_start, mul_plain, mul_done;
    logic [DW-1:0] mul_x, mul_y, mul_m, mul_res;
    logic [DW-1:0] p_w, q_w, n_w, val_w, inv_m, inv_a, pm_w, a_w, b_w;
    logic [PB-1:0] pm;
    logic [PB:0]   e_full;
    logic [DW:0]   crt_sum;
    logic [DW-1:0] t_new;

    assign p_w     = DW'(p_reg);
    assign q_w     = DW'(q_reg);
    assign n_w     = DW'(n_reg);
    assign val_w   = DW'(val_reg);
    assign inv_m   = which_reg ? q_w : p_w;
    assign inv_a   = which_reg ? p_w : q_w;
    assign pm      = which_reg ? q_reg : p_reg;
    assign pm_w    = DW'(pm);
    assign a_w     = k_reg[1] ? rp1_reg : rp0_reg;
    assign b_w     = k_reg[0] ? rq1_reg : rq0_reg;
    assign e_full  = ({1'b0, pm} + 1'b1) >> 2;
    assign crt_sum = {1'b0, t1c_reg} + {1'b0, mul_res};
    assign t_new   = (t0_reg >= mul_res) ? (t0_reg - mul_res) : (t0_reg + (inv_m - mul_res));

    assign in_stall     = (state_reg != S_IDLE);
    assign in_acc       = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign last_result  = out_last_reg;
    assign error_flag   = out_err_reg;

    rabin_div #(.W(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    rabin_mulmod #(.W(DW)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .plain   (mul_plain),
        .x       (mul_x),
        .y       (mul_y),
        .m       (mul_m),
        .done    (mul_done),
        .product (mul_res)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg <= PB'(7);
            q_reg <= PB'(11);
            n_reg <= 32'd77;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PRIME_P:        p_reg <= cfg_data[PB-1:0];
                CFG_PRIME_Q:        q_reg <= cfg_data[PB-1:0];
                CFG_PUBLIC_MODULUS: n_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // unit operand selection
    always_comb
    begin
        uses_div  = 1'b0;
        uses_mul  = 1'b0;
        div_a     = val_w;
        div_b     = n_w;
        mul_x     = acc_reg;
        mul_y     = acc_reg;
        mul_m     = n_w;
        mul_plain = 1'b0;
        case (state_reg)
            S_ENC_DIV:
            begin
                uses_div = 1'b1;
            end
            S_ENC_MUL:
            begin
                uses_mul = 1'b1;
            end
            S_INV_INIT:
            begin
                uses_div = 1'b1;
                div_a    = inv_a;
                div_b    = inv_m;
            end
            S_INV_DIV:
            begin
                uses_div = 1'b1;
                div_a    = r0_reg;
                div_b    = r1_reg;
            end
            S_INV_RED:
            begin
                uses_div = 1'b1;
                div_a    = qt_reg;
                div_b    = inv_m;
            end
            S_INV_MUL:
            begin
                uses_mul = 1'b1;
                mul_x    = qt_reg;
                mul_y    = t1_reg;
                mul_m    = inv_m;
            end
            S_PROD:
            begin
                uses_mul  = 1'b1;
                mul_plain = 1'b1;
                mul_x     = p_w;
                mul_y     = q_w;
            end
            S_RES_P:
            begin
                uses_div = 1'b1;
                div_b    = p_w;
            end
            S_RES_Q:
            begin
                uses_div = 1'b1;
                div_b    = q_w;
            end
            S_POW_MUL1:
            begin
                uses_mul = 1'b1;
                mul_y    = base_reg;
                mul_m    = pm_w;
            end
            S_POW_MUL2:
            begin
                uses_mul = 1'b1;
                mul_x    = base_reg;
                mul_y    = base_reg;
                mul_m    = pm_w;
            end
            S_CRT1:
            begin
                uses_mul = 1'b1;
                mul_x    = a_w;
                mul_y    = q_w;
                mul_m    = mm_reg;
            end
            S_CRT2:
            begin
                uses_mul = 1'b1;
                mul_x    = tc_reg;
                mul_y    = ip_reg;
                mul_m    = mm_reg;
            end
            S_CRT3:
            begin
                uses_mul = 1'b1;
                mul_x    = b_w;
                mul_y    = p_w;
                mul_m    = mm_reg;
            end
            S_CRT4:
            begin
                uses_mul = 1'b1;
                mul_x    = tc_reg;
                mul_y    = iq_reg;
                mul_m    = mm_reg;
            end
            default:
            begin
                uses_div = 1'b0;
            end
        endcase
        div_start = uses_div && !issued_reg;
        mul_start = uses_mul && !issued_reg;
        unit_done = issued_reg && ((uses_div && div_done) || (uses_mul && mul_done));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (operation == OP_DECRYPT)
                    begin
                        state_next = ((p_reg == '0) || (q_reg == '0)) ? S_ERR_EMIT : S_INV_BEGIN;
                    end
                    else
                    begin
                        state_next = (n_reg == '0) ? S_EMIT : S_ENC_DIV;
                    end
                end
            end
            S_ENC_DIV:  if (unit_done) state_next = S_ENC_MUL;
            S_ENC_MUL:  if (unit_done) state_next = S_EMIT;
            S_INV_BEGIN:
            begin
                state_next = (inv_m < DW'(2)) ? S_ERR_EMIT : S_INV_INIT;
            end
            S_INV_INIT: if (unit_done) state_next = S_INV_CHK;
            S_INV_CHK:
            begin
                if (r1_reg != '0)
                begin
                    state_next = S_INV_DIV;
                end
                else if (r0_reg != DW'(1))
                begin
                    state_next = S_ERR_EMIT;
                end
                else
                begin
                    state_next = which_reg ? S_PROD : S_INV_BEGIN;
                end
            end
            S_INV_DIV:  if (unit_done) state_next = S_INV_RED;
            S_INV_RED:  if (unit_done) state_next = S_INV_MUL;
            S_INV_MUL:  if (unit_done) state_next = S_INV_CHK;
            S_PROD:     if (unit_done) state_next = S_RES_P;
            S_RES_P:    if (unit_done) state_next = S_RES_Q;
            S_RES_Q:    if (unit_done) state_next = S_POW_BEGIN;
            S_POW_BEGIN: state_next = S_POW_CHK;
            S_POW_CHK:
            begin
                if (e_reg == '0)
                begin
                    state_next = S_NEG;
                end
                else
                begin
                    state_next = e_reg[0] ? S_POW_MUL1 : S_POW_MUL2;
                end
            end
            S_POW_MUL1: if (unit_done) state_next = S_POW_MUL2;
            S_POW_MUL2: if (unit_done) state_next = S_POW_CHK;
            S_NEG:      state_next = which_reg ? S_CRT1 : S_POW_BEGIN;
            S_CRT1:     if (unit_done) state_next = S_CRT2;
            S_CRT2:     if (unit_done) state_next = S_CRT3;
            S_CRT3:     if (unit_done) state_next = S_CRT4;
            S_CRT4:     if (unit_done) state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = res_last_reg ? S_IDLE : S_CRT1;
                end
            end
            S_ERR_EMIT:
            begin
                if (out_free && (k_reg == 2'd3))
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath register updates
    always_comb
    begin
        issued_next   = issued_reg;
        k_next        = k_reg;
        which_next    = which_reg;
        val_next      = val_reg;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        qt_next       = qt_reg;
        rm_next       = rm_reg;
        ip_next       = ip_reg;
        iq_next       = iq_reg;
        mm_next       = mm_reg;
        cp_next       = cp_reg;
        cq_next       = cq_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        e_next        = e_reg;
        rp0_next      = rp0_reg;
        rp1_next      = rp1_reg;
        rq0_next      = rq0_reg;
        rq1_next      = rq1_reg;
        tc_next       = tc_reg;
        t1c_next      = t1c_reg;
        res_next      = res_reg;
        res_last_next = res_last_reg;
        if (div_start || mul_start)
        begin
            issued_next = 1'b1;
        end
        else if (unit_done)
        begin
            issued_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    val_next      = value;
                    k_next        = 2'd0;
                    which_next    = 1'b0;
                    res_next      = '0;
                    res_last_next = 1'b1;
                end
            end
            S_ENC_DIV:
            begin
                if (unit_done) acc_next = div_rem;
            end
            S_ENC_MUL:
            begin
                if (unit_done) res_next = mul_res[31:0];
            end
            S_INV_BEGIN:
            begin
                r0_next = inv_m;
                t0_next = '0;
                t1_next = DW'(1);
            end
            S_INV_INIT:
            begin
                if (unit_done) r1_next = div_rem;
            end
            S_INV_CHK:
            begin
                if ((r1_reg == '0) && (r0_reg == DW'(1)))
                begin
                    if (which_reg)
                    begin
                        iq_next = t0_reg;
                    end
                    else
                    begin
                        ip_next    = t0_reg;
                        which_next = 1'b1;
                    end
                end
            end
            S_INV_DIV:
            begin
                if (unit_done)
                begin
                    qt_next = div_quo;
                    rm_next = div_rem;
                end
            end
            S_INV_RED:
            begin
                if (unit_done) qt_next = div_rem;
            end
            S_INV_MUL:
            begin
                if (unit_done)
                begin
                    r0_next = r1_reg;
                    r1_next = rm_reg;
                    t0_next = t1_reg;
                    t1_next = t_new;
                end
            end
            S_PROD:
            begin
                if (unit_done) mm_next = mul_res;
            end
            S_RES_P:
            begin
                if (unit_done) cp_next = div_rem;
            end
            S_RES_Q:
            begin
                if (unit_done)
                begin
                    cq_next    = div_rem;
                    which_next = 1'b0;
                end
            end
            S_POW_BEGIN:
            begin
                acc_next  = DW'(1);
                base_next = which_reg ? cq_reg : cp_reg;
                e_next    = e_full[PB-1:0];
            end
            S_POW_MUL1:
            begin
                if (unit_done) acc_next = mul_res;
            end
            S_POW_MUL2:
            begin
                if (unit_done)
                begin
                    base_next = mul_res;
                    e_next    = e_reg >> 1;
                end
            end
            S_NEG:
            begin
                if (which_reg)
                begin
                    rq0_next = acc_reg;
                    rq1_next = (acc_reg == '0) ? '0 : (pm_w - acc_reg);
                    k_next   = 2'd0;
                end
                else
                begin
                    rp0_next   = acc_reg;
                    rp1_next   = (acc_reg == '0) ? '0 : (pm_w - acc_reg);
                    which_next = 1'b1;
                end
            end
            S_CRT1, S_CRT3:
            begin
                if (unit_done) tc_next = mul_res;
            end
            S_CRT2:
            begin
                if (unit_done) t1c_next = mul_res;
            end
            S_CRT4:
            begin
                if (unit_done)
                begin
                    res_last_next = (k_reg == 2'd3);
                    if (crt_sum >= {1'b0, mm_reg})
                    begin
                        res_next = 32'(crt_sum - {1'b0, mm_reg});
                    end
                    else
                    begin
                        res_next = crt_sum[31:0];
                    end
                end
            end
            S_EMIT, S_ERR_EMIT:
            begin
                if (out_free) k_next = k_reg + 1'b1;
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if ((state_reg == S_EMIT) && out_free)
        begin
            out_valid_next = 1'b1;
            out_value_next = res_reg;
            out_last_next  = res_last_reg;
            out_err_next   = 1'b0;
        end
        else if ((state_reg == S_ERR_EMIT) && out_free)
        begin
            out_valid_next = 1'b1;
            out_value_next = '0;
            out_last_next  = (k_reg == 2'd3);
            out_err_next   = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        which_reg     <= which_next;
        val_reg       <= val_next;
        r0_reg        <= r0_next;
        r1_reg        <= r1_next;
        t0_reg        <= t0_next;
        t1_reg        <= t1_next;
        qt_reg        <= qt_next;
        rm_reg        <= rm_next;
        ip_reg        <= ip_next;
        iq_reg        <= iq_next;
        mm_reg        <= mm_next;
        cp_reg        <= cp_next;
        cq_reg        <= cq_next;
        acc_reg       <= acc_next;
        base_reg      <= base_next;
        e_reg         <= e_next;
        rp0_reg       <= rp0_next;
        rp1_reg       <= rp1_next;
        rq0_reg       <= rq0_next;
        rq1_reg       <= rq1_next;
        tc_reg        <= tc_next;
        t1c_reg       <= t1c_next;
        res_reg       <= res_next;
        res_last_reg  <= res_last_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

endmodule

// ----- rtl/core/rabin_chk.sv -----
// ----------------------------------------------------------------------------
// rabin_chk
// port-level checks of the rabin encrypt/decrypt block
// ----------------------------------------------------------------------------
module rabin_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_value,
    input logic        last_result,
    input logic        error_flag
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value)
            && $stable(last_result) && $stable(error_flag))
        else $error("stalled result changed");

    // an accepted request keeps the block busy
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block ready right after a request");

    // no new request before the last result of the current one
    a_busy_mid_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> in_stall)
        else $error("ready while results still pending");

endmodule

bind rabin_encrypt_decrypt rabin_chk u_rabin_chk (.*);
